// ===== hw/rtl/onc_pkg.sv =====
// Shared types and constants for the object name classifier.
// No dependencies; object_name_classifier and onc_dec_feed refer to it by scoped names.
package onc_pkg;

  typedef enum logic [1:0] {
    KIND_REFUSED  = 2'd0,
    KIND_PREFIX   = 2'd1,
    KIND_ARTIFACT = 2'd2,
    KIND_SHIPMENT = 2'd3
  } kind_t;

  localparam int MAX_NAME_LEN_DEF = 127;

  // Name layout
  localparam int SEED_DIGITS   = 32;
  localparam int SEED_HALF     = 16;
  localparam int HEX_SPAN      = 64;
  localparam int SEP_POS       = 32;
  localparam int DEC_START_POS = 32 + 1 + 5;
  localparam int DIGEST_LEN    = 64 + 3;
  localparam int MIN_SHIP_LEN  = 32 + 1 + 1 + 1 + 1 + 5;

  // Decimal digit counters
  localparam int          DEC_CNT_W = 5;
  localparam logic [4:0]  DEC_CNT_MAX = 5'd31;

  localparam logic [7:0]  CH_DASH = 8'h2D;
  localparam logic [39:0] PADS_WORD = 40'h2E_70_61_64_73;
  localparam logic [23:0] I8_WORD   = 24'h2E_69_38;

  // Prefix names, left aligned in a 13-byte field
  localparam int LIT_W    = 8 * 13;
  localparam int NUM_LITS = 3;
  localparam logic [LIT_W-1:0] LIT_KV  = {"prefix.kv", 32'h0};
  localparam logic [LIT_W-1:0] LIT_SIG = "prefix.kv.sig";
  localparam logic [LIT_W-1:0] LIT_TXT = {"prefix.txt", 24'h0};
  localparam int LEN_KV  = 9;
  localparam int LEN_SIG = 13;
  localparam int LEN_TXT = 10;

  function automatic logic [3:0] lit_len(input logic [1:0] k);
    logic [3:0] len;
    case (k)
      2'd0:    len = 4'(LEN_KV);
      2'd1:    len = 4'(LEN_SIG);
      2'd2:    len = 4'(LEN_TXT);
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [3:0] idx);
    logic [LIT_W-1:0] s;
    logic [7:0]       b;
    case (k)
      2'd0:    s = LIT_KV;
      2'd1:    s = LIT_SIG;
      2'd2:    s = LIT_TXT;
      default: s = '0;
    endcase
    if (idx > 4'd12) begin
      b = 8'h00;
    end else begin
      b = s[8 * (12 - int'(idx)) +: 8];
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/onc_in_if.sv =====
// Request channel of the object name classifier: one name byte per request.
// Depends on nothing.
interface onc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

// ===== hw/rtl/onc_out_if.sv =====
// Result channel of the object name classifier: one verdict per name.
// Depends on nothing.
interface onc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] seed_upper;
  logic [63:0] seed_lower;
  logic [63:0] start_index;
  logic [63:0] run_count;

  modport source (output valid, kind, seed_upper, seed_lower, start_index, run_count,
                  input ready);
  modport sink   (input valid, kind, seed_upper, seed_lower, start_index, run_count,
                  output ready);
endinterface

// ===== hw/rtl/object_name_classifier.sv =====
// Object name classifier top level: byte scan, snapshot stage, result register.
// Depends on onc_pkg, onc_in_if, onc_out_if and onc_dec_feed.
//
//   channel  | dir | payload                                          | moves
//   in_chan  | in  | ch[7:0], last                                    | one byte per request
//   out_chan | out | kind[1:0], seed_upper, seed_lower, start_index,  | one per name
//            |     | run_count (64 bits each)                         |
//
// One byte is taken every cycle while in_chan.ready is high; the scan state updates in the accepting cycle.
// A name's verdict passes after its last byte through the snapshot register, then the result register.
// The only stall source is out_chan.ready; in_chan.ready drops while a snapshot waits.
// Reset (rst_n low, synchronous) clears the scan state and both valid flags.
module object_name_classifier #(
  parameter int MAX_NAME_LEN = onc_pkg::MAX_NAME_LEN_DEF
) (
  input logic        clk,
  input logic        rst_n,
  onc_in_if.sink     in_chan,
  onc_out_if.source  out_chan
);

  localparam int POS_W = $clog2(MAX_NAME_LEN + 2);

  typedef enum logic [2:0] {
    PH_SEED  = 3'b001,
    PH_START = 3'b010,
    PH_COUNT = 3'b100
  } phase_t;

  typedef struct packed {
    logic        prefix;
    logic        artifact;
    logic        ship_ok;
    logic [63:0] seed_hi;
    logic [63:0] seed_lo;
    logic [63:0] first;
    logic [63:0] second;
  } snap_t;

  typedef struct packed {
    onc_pkg::kind_t kind;
    logic [63:0]    seed_hi;
    logic [63:0]    seed_lo;
    logic [63:0]    first;
    logic [63:0]    second;
  } res_t;

  // scan state
  logic [POS_W-1:0]              pos_r, pos_upd, pos_nxt;
  logic [39:0]                   win_r, win_upd, win_nxt;
  logic [1:0]                    hex_r, hex_upd, hex_nxt;
  logic [2:0]                    lit_r, lit_upd, lit_nxt;
  phase_t                        ph_r, ph_upd, ph_nxt;
  logic [63:0]                   shi_r, shi_upd, shi_nxt;
  logic [63:0]                   slo_r, slo_upd, slo_nxt;
  logic [63:0]                   first_r, first_upd, first_nxt;
  logic [63:0]                   second_r, second_upd, second_nxt;
  logic [onc_pkg::DEC_CNT_W-1:0] c1_r, c1_upd, c1_nxt;
  logic [onc_pkg::DEC_CNT_W-1:0] c2_r, c2_upd, c2_nxt;
  logic [2:0]                    err_r, err_upd, err_nxt;

  // pipeline
  logic  snap_v_r, snap_v_nxt;
  snap_t snap_r, snap_nxt;
  logic  out_v_r, out_v_nxt;
  res_t  res_r, res_nxt;

  logic in_acc, in_last_acc, snap_adv;

  // byte helpers
  logic [7:0]  c, w;
  logic        hex_ok;
  logic [3:0]  hv;
  logic        parse_en;
  logic [63:0] f1_acc, f2_acc;
  logic [onc_pkg::DEC_CNT_W-1:0] f1_cnt, f2_cnt;
  logic        f1_bad, f2_bad;
  logic        fin_prefix;
  logic [64:0] dec_sum;

  assign snap_adv      = !out_v_r || out_chan.ready;
  assign in_chan.ready = !snap_v_r || snap_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_last_acc   = in_acc && in_chan.last;

  assign c  = in_chan.ch;
  assign w  = win_r[39:32];
  assign hex_ok = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66));
  assign hv = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  assign parse_en = (pos_r >= POS_W'(onc_pkg::DEC_START_POS))
                    && (pos_r <= POS_W'(MAX_NAME_LEN));

  onc_dec_feed u_feed_start (
    .acc(first_r), .cnt(c1_r), .ch(w),
    .acc_nxt(f1_acc), .cnt_nxt(f1_cnt), .bad(f1_bad)
  );

  onc_dec_feed u_feed_count (
    .acc(second_r), .cnt(c2_r), .ch(w),
    .acc_nxt(f2_acc), .cnt_nxt(f2_cnt), .bad(f2_bad)
  );

  // per-byte update
  always_comb begin
    pos_upd    = pos_r;
    win_upd    = {win_r[31:0], c};
    hex_upd    = hex_r;
    lit_upd    = lit_r;
    ph_upd     = ph_r;
    shi_upd    = shi_r;
    slo_upd    = slo_r;
    first_upd  = first_r;
    second_upd = second_r;
    c1_upd     = c1_r;
    c2_upd     = c2_r;
    err_upd    = err_r;

    for (int k = 0; k < onc_pkg::NUM_LITS; k++) begin
      if (!((pos_r < POS_W'(onc_pkg::lit_len(2'(k))))
            && (onc_pkg::lit_char(2'(k), pos_r[3:0]) == c))) begin
        lit_upd[k] = 1'b0;
      end
    end

    if ((pos_r < POS_W'(onc_pkg::HEX_SPAN)) && !hex_ok) begin
      hex_upd[1] = 1'b0;
      if (pos_r < POS_W'(onc_pkg::SEED_DIGITS)) begin
        hex_upd[0] = 1'b0;
      end
    end

    if ((pos_r < POS_W'(onc_pkg::SEED_DIGITS)) && hex_ok) begin
      if (pos_r < POS_W'(onc_pkg::SEED_HALF)) begin
        shi_upd = {shi_r[59:0], hv};
      end else begin
        slo_upd = {slo_r[59:0], hv};
      end
    end

    if (pos_r == POS_W'(onc_pkg::SEP_POS)) begin
      if (c != onc_pkg::CH_DASH) begin
        err_upd[2] = 1'b1;
      end
      ph_upd = PH_START;
    end

    // the oldest windowed byte feeds the decimals, so the suffix never does
    if (parse_en) begin
      unique case (ph_r)
        PH_START: begin
          if (w == onc_pkg::CH_DASH) begin
            ph_upd = PH_COUNT;
          end else if (f1_bad) begin
            err_upd[0] = 1'b1;
          end else begin
            first_upd = f1_acc;
            c1_upd    = f1_cnt;
          end
        end
        PH_COUNT: begin
          if (f2_bad) begin
            err_upd[1] = 1'b1;
          end else begin
            second_upd = f2_acc;
            c2_upd     = f2_cnt;
          end
        end
        default: ;
      endcase
    end

    if (pos_r <= POS_W'(MAX_NAME_LEN)) begin
      pos_upd = pos_r + 1'b1;
    end
  end

  // verdict ingredients from the updated state
  always_comb begin
    fin_prefix = 1'b0;
    for (int k = 0; k < onc_pkg::NUM_LITS; k++) begin
      if (lit_upd[k] && (pos_upd == POS_W'(onc_pkg::lit_len(2'(k))))) begin
        fin_prefix = 1'b1;
      end
    end

    snap_nxt.prefix   = fin_prefix;
    snap_nxt.artifact = (pos_upd == POS_W'(onc_pkg::DIGEST_LEN))
                        && (win_upd[23:0] == onc_pkg::I8_WORD) && hex_upd[1];
    snap_nxt.ship_ok  = (pos_upd >= POS_W'(onc_pkg::MIN_SHIP_LEN))
                        && (pos_upd <= POS_W'(MAX_NAME_LEN))
                        && hex_upd[0] && (err_upd == 3'b000)
                        && (win_upd == onc_pkg::PADS_WORD) && (ph_upd == PH_COUNT)
                        && (c1_upd != '0) && (c2_upd != '0) && (second_upd != 64'd0);
    snap_nxt.seed_hi  = shi_upd;
    snap_nxt.seed_lo  = slo_upd;
    snap_nxt.first    = first_upd;
    snap_nxt.second   = second_upd;
  end

  // after the last byte drop back to the empty-name state
  always_comb begin
    if (in_last_acc) begin
      pos_nxt    = '0;
      win_nxt    = '0;
      hex_nxt    = 2'b11;
      lit_nxt    = 3'b111;
      ph_nxt     = PH_SEED;
      shi_nxt    = '0;
      slo_nxt    = '0;
      first_nxt  = '0;
      second_nxt = '0;
      c1_nxt     = '0;
      c2_nxt     = '0;
      err_nxt    = '0;
    end else if (in_acc) begin
      pos_nxt    = pos_upd;
      win_nxt    = win_upd;
      hex_nxt    = hex_upd;
      lit_nxt    = lit_upd;
      ph_nxt     = ph_upd;
      shi_nxt    = shi_upd;
      slo_nxt    = slo_upd;
      first_nxt  = first_upd;
      second_nxt = second_upd;
      c1_nxt     = c1_upd;
      c2_nxt     = c2_upd;
      err_nxt    = err_upd;
    end else begin
      pos_nxt    = pos_r;
      win_nxt    = win_r;
      hex_nxt    = hex_r;
      lit_nxt    = lit_r;
      ph_nxt     = ph_r;
      shi_nxt    = shi_r;
      slo_nxt    = slo_r;
      first_nxt  = first_r;
      second_nxt = second_r;
      c1_nxt     = c1_r;
      c2_nxt     = c2_r;
      err_nxt    = err_r;
    end
  end

  // result stage: range check of start plus count, then pick the kind
  assign dec_sum = {1'b0, snap_r.first} + {1'b0, snap_r.second};

  always_comb begin
    res_nxt = '0;
    priority if (snap_r.prefix) begin
      res_nxt.kind = onc_pkg::KIND_PREFIX;
    end else if (snap_r.artifact) begin
      res_nxt.kind = onc_pkg::KIND_ARTIFACT;
    end else if (snap_r.ship_ok && !dec_sum[64]) begin
      res_nxt.kind    = onc_pkg::KIND_SHIPMENT;
      res_nxt.seed_hi = snap_r.seed_hi;
      res_nxt.seed_lo = snap_r.seed_lo;
      res_nxt.first   = snap_r.first;
      res_nxt.second  = snap_r.second;
    end else begin
      res_nxt.kind = onc_pkg::KIND_REFUSED;
    end
  end

  always_comb begin
    if (in_last_acc) begin
      snap_v_nxt = 1'b1;
    end else if (snap_adv) begin
      snap_v_nxt = 1'b0;
    end else begin
      snap_v_nxt = snap_v_r;
    end

    if (snap_adv) begin
      out_v_nxt = snap_v_r;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      win_r    <= '0;
      hex_r    <= 2'b11;
      lit_r    <= 3'b111;
      ph_r     <= PH_SEED;
      shi_r    <= '0;
      slo_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      c1_r     <= '0;
      c2_r     <= '0;
      err_r    <= '0;
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      win_r    <= win_nxt;
      hex_r    <= hex_nxt;
      lit_r    <= lit_nxt;
      ph_r     <= ph_nxt;
      shi_r    <= shi_nxt;
      slo_r    <= slo_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      c1_r     <= c1_nxt;
      c2_r     <= c2_nxt;
      err_r    <= err_nxt;
      snap_v_r <= snap_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_last_acc) begin
      snap_r <= snap_nxt;
    end
    if (snap_adv && snap_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.kind        = res_r.kind;
  assign out_chan.seed_upper  = res_r.seed_hi;
  assign out_chan.seed_lower  = res_r.seed_lo;
  assign out_chan.start_index = res_r.first;
  assign out_chan.run_count   = res_r.second;

  // a refused or non-shipment verdict carries no numbers
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind != onc_pkg::KIND_SHIPMENT)) |->
      ((out_chan.seed_upper == 64'd0) && (out_chan.seed_lower == 64'd0)
       && (out_chan.start_index == 64'd0) && (out_chan.run_count == 64'd0)))
    else $error("non-shipment verdict with nonzero fields");

  a_ship_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind == onc_pkg::KIND_SHIPMENT)) |->
      (out_chan.run_count != 64'd0))
    else $error("shipment verdict with zero count");

  a_name_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_last_acc |=> ((pos_r == '0) && (ph_r == PH_SEED) && (err_r == 3'b000)))
    else $error("scan state not cleared after final byte");

  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_v_r && !snap_adv) |=> (snap_v_r && $stable(snap_r)))
    else $error("waiting snapshot lost");

endmodule

// ===== hw/rtl/onc_dec_feed.sv =====
// One step of a canonical decimal parser: append a digit, flag a bad byte.
// Depends on onc_pkg.
module onc_dec_feed (
  input  logic [63:0]                   acc,
  input  logic [onc_pkg::DEC_CNT_W-1:0] cnt,
  input  logic [7:0]                    ch,
  output logic [63:0]                   acc_nxt,
  output logic [onc_pkg::DEC_CNT_W-1:0] cnt_nxt,
  output logic                          bad
);

  logic        is_digit;
  logic [67:0] wide;

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);

  // acc * 10 + d as a shift-add; any carry beyond 64 bits is an overflow
  assign wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {64'b0, ch[3:0]};

  assign acc_nxt = wide[63:0];
  assign cnt_nxt = (cnt == onc_pkg::DEC_CNT_MAX) ? cnt : cnt + 1'b1;
  assign bad     = !is_digit || ((cnt != '0) && (acc == 64'd0)) || (wide[67:64] != 4'd0);

endmodule
